/* design/gpb_pkg.sv */
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared constants, types and mask helpers for the GPIO register bank.
// ----------------------------------------------------------------------------
package gpb_pkg;

    localparam int NUM_PINS = 54;

    localparam int IDX_W         = 6;
    localparam int DATA_W        = 32;
    localparam int FSEL_WORDS    = 6;
    localparam int FSEL_PER_WORD = 10;
    localparam int FSEL_BITS     = 3 * FSEL_PER_WORD;
    localparam int PULL_WORDS    = 4;
    localparam int PULL_PER_WORD = 16;
    localparam int FSEL_IW       = $clog2(FSEL_WORDS);
    localparam int PULL_IW       = $clog2(PULL_WORDS);

    // pins that own a function field
    localparam int FSEL_PINS = (NUM_PINS < FSEL_WORDS * FSEL_PER_WORD) ?
                               NUM_PINS : FSEL_WORDS * FSEL_PER_WORD;

    // word map (byte offsets / 4)
    localparam logic [IDX_W-1:0] FSEL_BASE = '0;
    localparam logic [IDX_W-1:0] SET_BASE  = IDX_W'(32'h1c / 4);
    localparam logic [IDX_W-1:0] CLR_BASE  = IDX_W'(32'h28 / 4);
    localparam logic [IDX_W-1:0] LEV_BASE  = IDX_W'(32'h34 / 4);
    localparam logic [IDX_W-1:0] PULL_BASE = IDX_W'(32'he4 / 4);

    localparam logic [2:0] FSEL_FIELD  = 3'd7;
    localparam logic [1:0] PULL_FIELD  = 2'd3;
    localparam logic [2:0] OUTPUT_CODE = 3'd1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // register group codes
    localparam logic [2:0] KIND_FSEL = 3'd0;
    localparam logic [2:0] KIND_SET  = 3'd1;
    localparam logic [2:0] KIND_CLR  = 3'd2;
    localparam logic [2:0] KIND_LEV  = 3'd3;
    localparam logic [2:0] KIND_PULL = 3'd4;
    localparam logic [2:0] KIND_BAD  = 3'd5;

    typedef logic [NUM_PINS-1:0]                    t_pins;
    typedef logic [FSEL_WORDS-1:0][FSEL_BITS-1:0]   t_fsel_bank;
    typedef logic [PULL_WORDS-1:0][DATA_W-1:0]      t_pull_bank;

    typedef struct packed {
        logic [2:0]         kind;
        logic [FSEL_IW-1:0] fsel_w;
        logic               upper;   // second word of set/clear/level pair
        logic [PULL_IW-1:0] pull_w;
    } t_decode;

    function automatic logic [FSEL_BITS-1:0] fsel_mask(input logic [FSEL_IW-1:0] w);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < FSEL_PER_WORD; k++) begin
            if (int'(w) * FSEL_PER_WORD + k < NUM_PINS) begin
                m[3*k +: 3] = FSEL_FIELD;
            end
        end
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] pull_mask(input logic [PULL_IW-1:0] w);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int k = 0; k < PULL_PER_WORD; k++) begin
            if (int'(w) * PULL_PER_WORD + k < NUM_PINS) begin
                m[2*k +: 2] = PULL_FIELD;
            end
        end
        return m;
    endfunction

    function automatic t_pins output_enables(input t_fsel_bank f);
        t_pins oe;
        oe = '0;
        for (int p = 0; p < FSEL_PINS; p++) begin
            oe[p] = (f[p / FSEL_PER_WORD][3*(p % FSEL_PER_WORD) +: 3] == OUTPUT_CODE);
        end
        return oe;
    endfunction

endpackage

/* design/gpb_decode.sv */
// ----------------------------------------------------------------------------
// gpb_decode
// Word index decode into register group and word offset.
// ----------------------------------------------------------------------------
module gpb_decode (
    input  logic [gpb_pkg::IDX_W-1:0] i_reg_index,
    output gpb_pkg::t_decode          o_dec
);

    always_comb begin
        o_dec        = '0;
        o_dec.kind   = gpb_pkg::KIND_BAD;
        if (i_reg_index < gpb_pkg::FSEL_BASE + gpb_pkg::IDX_W'(gpb_pkg::FSEL_WORDS)) begin
            o_dec.kind   = gpb_pkg::KIND_FSEL;
            o_dec.fsel_w = gpb_pkg::FSEL_IW'(i_reg_index - gpb_pkg::FSEL_BASE);
        end else if (i_reg_index == gpb_pkg::SET_BASE ||
                     i_reg_index == gpb_pkg::SET_BASE + 1'b1) begin
            o_dec.kind  = gpb_pkg::KIND_SET;
            o_dec.upper = (i_reg_index != gpb_pkg::SET_BASE);
        end else if (i_reg_index == gpb_pkg::CLR_BASE ||
                     i_reg_index == gpb_pkg::CLR_BASE + 1'b1) begin
            o_dec.kind  = gpb_pkg::KIND_CLR;
            o_dec.upper = (i_reg_index != gpb_pkg::CLR_BASE);
        end else if (i_reg_index == gpb_pkg::LEV_BASE ||
                     i_reg_index == gpb_pkg::LEV_BASE + 1'b1) begin
            o_dec.kind  = gpb_pkg::KIND_LEV;
            o_dec.upper = (i_reg_index != gpb_pkg::LEV_BASE);
        end else if (i_reg_index >= gpb_pkg::PULL_BASE &&
                     i_reg_index < gpb_pkg::PULL_BASE + gpb_pkg::IDX_W'(gpb_pkg::PULL_WORDS)) begin
            o_dec.kind   = gpb_pkg::KIND_PULL;
            o_dec.pull_w = gpb_pkg::PULL_IW'(i_reg_index - gpb_pkg::PULL_BASE);
        end
    end

endmodule

/* design/gpb_state.sv */
// ----------------------------------------------------------------------------
// gpb_state
// Function, pull and output latch registers with their read mux.
// ----------------------------------------------------------------------------
module gpb_state (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  gpb_pkg::t_decode           i_dec,
    input  logic                       i_action,
    input  logic [gpb_pkg::DATA_W-1:0] i_write_data,
    input  gpb_pkg::t_pins             i_pin_levels,
    output logic [gpb_pkg::DATA_W-1:0] o_read_data,
    output gpb_pkg::t_pins             o_next_drive,
    output gpb_pkg::t_pins             o_next_oe
);

    gpb_pkg::t_fsel_bank r_fsel, n_fsel;
    gpb_pkg::t_pull_bank r_pull, n_pull;
    gpb_pkg::t_pins      r_latch, n_latch;
    gpb_pkg::t_pins      r_oe, n_oe;

    logic                        wr;
    logic [2*gpb_pkg::DATA_W-1:0] wide;
    logic [2*gpb_pkg::DATA_W-1:0] lev;

    assign wr   = (i_action == gpb_pkg::ACT_WRITE);
    assign wide = i_dec.upper ? {i_write_data, {gpb_pkg::DATA_W{1'b0}}} :
                                {{gpb_pkg::DATA_W{1'b0}}, i_write_data};
    // output pins reflect the latch, all others the pad
    assign lev  = (2*gpb_pkg::DATA_W)'((r_latch & r_oe) | (i_pin_levels & ~r_oe));

    always_comb begin
        n_fsel      = r_fsel;
        n_pull      = r_pull;
        n_latch     = r_latch;
        o_read_data = '0;
        case (i_dec.kind)
            gpb_pkg::KIND_FSEL: begin
                if (wr) begin
                    n_fsel[i_dec.fsel_w] = i_write_data[gpb_pkg::FSEL_BITS-1:0] &
                                           gpb_pkg::fsel_mask(i_dec.fsel_w);
                end else begin
                    o_read_data = gpb_pkg::DATA_W'(r_fsel[i_dec.fsel_w]);
                end
            end
            gpb_pkg::KIND_SET: begin
                if (wr) begin
                    n_latch = r_latch | wide[gpb_pkg::NUM_PINS-1:0];
                end
            end
            gpb_pkg::KIND_CLR: begin
                if (wr) begin
                    n_latch = r_latch & ~wide[gpb_pkg::NUM_PINS-1:0];
                end
            end
            gpb_pkg::KIND_LEV: begin
                if (!wr) begin
                    o_read_data = i_dec.upper ? lev[2*gpb_pkg::DATA_W-1:gpb_pkg::DATA_W] :
                                                lev[gpb_pkg::DATA_W-1:0];
                end
            end
            gpb_pkg::KIND_PULL: begin
                if (wr) begin
                    n_pull[i_dec.pull_w] = i_write_data & gpb_pkg::pull_mask(i_dec.pull_w);
                end else begin
                    o_read_data = r_pull[i_dec.pull_w];
                end
            end
            default: begin
            end
        endcase
        n_oe = gpb_pkg::output_enables(n_fsel);
    end

    assign o_next_drive = n_latch;
    assign o_next_oe    = n_oe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel  <= '0;
            r_pull  <= '0;
            r_latch <= '0;
            r_oe    <= '0;
        end else if (i_fire) begin
            r_fsel  <= n_fsel;
            r_pull  <= n_pull;
            r_latch <= n_latch;
            r_oe    <= n_oe;
        end
    end

endmodule

/* design/gpio_register_bank.sv */
// ----------------------------------------------------------------------------
// gpio_register_bank
// GPIO controller behind 32-bit word registers, one bus access per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one access per beat:
//   read or write, word index, write data and the sampled pad levels.
//   Output channel (o_out_valid / i_out_stall) returns one result beat per
//   access: read data (zero on writes and unmapped words), bad-address flag,
//   and the pin drive and output-enable vectors as left by that access.
//   The input register loads at the accepting edge; the result register
//   loads the access once it is free (not held by a receiver stall).
//   Throughput: one access per cycle while the receiver does not stall;
//   the decode, register update and read mux sit between the two registers.
//   Reset (synchronous, active low) clears all function and pull words and
//   the output latch, so every pin is an input, and empties both stages.
//   When the receiver stalls, the result register holds its beat; the input
//   register still takes one more access if empty, after which o_in_stall rises
//   until the result beat is taken.
// ----------------------------------------------------------------------------
module gpio_register_bank (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // access channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [gpb_pkg::IDX_W-1:0]    i_reg_index,
    input  logic [gpb_pkg::DATA_W-1:0]   i_write_data,
    input  logic [gpb_pkg::NUM_PINS-1:0] i_pin_levels,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gpb_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_bad_address,
    output logic [gpb_pkg::NUM_PINS-1:0] o_pin_drive,
    output logic [gpb_pkg::NUM_PINS-1:0] o_pin_output_enable
);

    // input stage
    logic                       r_in_valid;
    logic                       r_action;
    logic [gpb_pkg::IDX_W-1:0]  r_reg_index;
    logic [gpb_pkg::DATA_W-1:0] r_write_data;
    gpb_pkg::t_pins             r_pin_levels;

    // result stage
    logic                       r_out_valid;
    logic [gpb_pkg::DATA_W-1:0] r_read_data;
    logic                       r_bad;
    gpb_pkg::t_pins             r_drive;
    gpb_pkg::t_pins             r_oe;

    logic                       out_load;   // result register free this cycle
    logic                       in_load;    // input register free this cycle
    logic                       fire;       // access commits to state
    gpb_pkg::t_decode           dec;
    logic [gpb_pkg::DATA_W-1:0] rd_data;
    gpb_pkg::t_pins             next_drive;
    gpb_pkg::t_pins             next_oe;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_load;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_action     <= i_action;
            r_reg_index  <= i_reg_index;
            r_write_data <= i_write_data;
            r_pin_levels <= i_pin_levels;
        end
    end

    gpb_decode u_decode (
        .i_reg_index (r_reg_index),
        .o_dec       (dec)
    );

    gpb_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_dec        (dec),
        .i_action     (r_action),
        .i_write_data (r_write_data),
        .i_pin_levels (r_pin_levels),
        .o_read_data  (rd_data),
        .o_next_drive (next_drive),
        .o_next_oe    (next_oe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    // writes return zero; unmapped words flag and read zero
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data <= rd_data;
            r_bad       <= (dec.kind == gpb_pkg::KIND_BAD);
            r_drive     <= next_drive;
            r_oe        <= next_oe;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_bad_address       = r_bad;
    assign o_pin_drive         = r_drive;
    assign o_pin_output_enable = r_oe;

    // an unmapped word never returns data
    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_address |-> o_read_data == '0)
        else $error("bad address beat carries read data");

    // back-pressure only while an access is held in the input stage
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input stage");

    // a committed access always yields a result beat next cycle
    a_fire_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("committed access produced no result beat");

endmodule
